/* rtl/core/ldt_pkg.sv */
// Shared types and constants for the LZW dictionary tree lookup block.
`timescale 1ns / 1ps

package ldt_pkg;

    localparam int CODE_BITS   = 12;
    localparam int TABLE_DEPTH = 1 << CODE_BITS;
    localparam int BYTE_W      = 8;
    localparam int ROOT_COUNT  = 1 << BYTE_W;
    localparam int OUT_CODE_W  = 12;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [CODE_BITS:0]   t_count;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              has_prefix;
        t_code             prefix;
        logic              has_first;
        t_code             first;
        logic              has_left;
        t_code             left;
        logic              has_right;
        t_code             right;
    } t_entry;

    typedef enum logic {
        LINK_FIRST,
        LINK_CHILD
    } t_link;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_BYTE,
        RES_HIT,
        RES_NEW
    } t_res;

    typedef struct packed {
        logic  load;
        logic  clear;
        logic  rd;
        logic  follow;
        t_link link;
        logic  wlink;
        logic  wnew;
        logic  set_res;
        t_res  res;
        logic  emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hp;
        logic            full;
        logic            has_first;
        logic            byte_eq;
        logic            link_ok;
        logic            out_free;
        logic            init_busy;
    } t_dp_sts;

endpackage

/* rtl/core/ldt_in_if.sv */
// Input channel: one lookup, append or clear transaction.
`timescale 1ns / 1ps

interface ldt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        prefix_present;
    logic [11:0] prefix_code;
    logic [7:0]  next_byte;

    modport source (output valid, operation, prefix_present, prefix_code, next_byte,
                    input ready);
    modport sink   (input valid, operation, prefix_present, prefix_code, next_byte,
                    output ready);
endinterface

/* rtl/core/ldt_out_if.sv */
// Output channel: one result transaction.
`timescale 1ns / 1ps

interface ldt_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] code;
    logic        table_full;

    modport source (output valid, found, code, table_full, input ready);
    modport sink   (input valid, found, code, table_full, output ready);
endinterface

/* rtl/core/ldt_datapath.sv */
// Datapath: code table memory, root valid bits, code counters and result registers.
`timescale 1ns / 1ps

module ldt_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ldt_pkg::t_dp_cmd       i_cmd,
    output ldt_pkg::t_dp_sts       o_sts,
    input  logic [1:0]             i_operation,
    input  logic                   i_prefix_present,
    input  logic [11:0]            i_prefix_code,
    input  logic [7:0]             i_next_byte,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_found,
    output logic [11:0]            o_code,
    output logic                   o_table_full
);

    ldt_pkg::t_entry r_mem [ldt_pkg::TABLE_DEPTH];
    ldt_pkg::t_entry r_rdata;
    logic            r_rd_root;
    logic            r_rd_rv;

    logic [ldt_pkg::OP_W-1:0]   r_op;
    logic                       r_hp;
    ldt_pkg::t_code             r_pc;
    logic [ldt_pkg::BYTE_W-1:0] r_b;
    ldt_pkg::t_code             r_idx;

    ldt_pkg::t_count                  r_next_free;
    logic [ldt_pkg::ROOT_COUNT-1:0]   r_root_valid;
    logic                             r_init_busy;
    ldt_pkg::t_code                   r_init_addr;

    logic           r_res_found;
    ldt_pkg::t_code r_res_code;
    logic           r_res_full;

    logic           r_out_valid;
    logic           r_out_found;
    ldt_pkg::t_code r_out_code;
    logic           r_out_full;

    ldt_pkg::t_entry cur;
    ldt_pkg::t_entry link_data;
    ldt_pkg::t_entry new_data;
    ldt_pkg::t_entry wdata;
    ldt_pkg::t_code  waddr;
    ldt_pkg::t_code  rd_addr;
    ldt_pkg::t_code  link_code;
    ldt_pkg::t_code  new_code;
    logic            go_left;
    logic            we;
    logic            idx_is_root;

    assign new_code    = r_next_free[ldt_pkg::CODE_BITS-1:0];
    assign idx_is_root = r_idx < ldt_pkg::t_code'(ldt_pkg::ROOT_COUNT);

    // Roots not linked since reset or clear read as an empty entry holding their own byte.
    always_comb begin
        cur = r_rdata;
        if (r_rd_root && !r_rd_rv) begin
            cur          = '0;
            cur.byte_val = r_idx[ldt_pkg::BYTE_W-1:0];
        end
    end

    assign go_left   = r_b < cur.byte_val;
    assign link_code = (i_cmd.link == ldt_pkg::LINK_FIRST) ? cur.first :
                       (go_left ? cur.left : cur.right);
    assign rd_addr   = i_cmd.follow ? link_code : r_idx;

    always_comb begin
        link_data = cur;
        if (i_cmd.link == ldt_pkg::LINK_FIRST) begin
            link_data.has_first = 1'b1;
            link_data.first     = new_code;
        end else if (go_left) begin
            link_data.has_left  = 1'b1;
            link_data.left      = new_code;
        end else begin
            link_data.has_right = 1'b1;
            link_data.right     = new_code;
        end
    end

    always_comb begin
        new_data            = '0;
        new_data.byte_val   = r_b;
        new_data.has_prefix = r_hp;
        new_data.prefix     = r_pc;
    end

    // Table writes; the clearing pass after reset takes over, one entry per cycle.
    always_comb begin
        we    = i_cmd.wlink | i_cmd.wnew;
        waddr = i_cmd.wlink ? r_idx : new_code;
        wdata = i_cmd.wlink ? link_data : new_data;
        if (r_init_busy) begin
            we    = 1'b1;
            waddr = r_init_addr;
            wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata   <= r_mem[rd_addr];
            r_rd_root <= rd_addr < ldt_pkg::t_code'(ldt_pkg::ROOT_COUNT);
            r_rd_rv   <= r_root_valid[rd_addr[ldt_pkg::BYTE_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_hp  <= i_prefix_present;
            r_pc  <= ldt_pkg::t_code'(i_prefix_code);
            r_b   <= i_next_byte;
            r_idx <= ldt_pkg::t_code'(i_prefix_code);
        end else if (i_cmd.follow) begin
            r_idx <= link_code;
        end
        if (i_cmd.set_res) begin
            case (i_cmd.res)
                ldt_pkg::RES_FULL: begin
                    r_res_found <= 1'b0;
                    r_res_code  <= '0;
                    r_res_full  <= 1'b1;
                end
                ldt_pkg::RES_BYTE: begin
                    r_res_found <= 1'b1;
                    r_res_code  <= ldt_pkg::t_code'(r_b);
                    r_res_full  <= 1'b0;
                end
                ldt_pkg::RES_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_code  <= r_idx;
                    r_res_full  <= 1'b0;
                end
                ldt_pkg::RES_NEW: begin
                    r_res_found <= 1'b0;
                    r_res_code  <= new_code;
                    r_res_full  <= 1'b0;
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_code  <= '0;
                    r_res_full  <= 1'b0;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out_found <= r_res_found;
            r_out_code  <= r_res_code;
            r_out_full  <= r_res_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free  <= ldt_pkg::t_count'(ldt_pkg::ROOT_COUNT);
            r_root_valid <= '0;
            r_out_valid  <= 1'b0;
            r_init_busy  <= 1'b1;
            r_init_addr  <= '0;
        end else begin
            if (r_init_busy) begin
                r_init_addr <= r_init_addr + 1'b1;
                if (r_init_addr == ldt_pkg::t_code'(ldt_pkg::TABLE_DEPTH - 1)) begin
                    r_init_busy <= 1'b0;
                end
            end
            if (i_cmd.clear) begin
                r_next_free  <= ldt_pkg::t_count'(ldt_pkg::ROOT_COUNT);
                r_root_valid <= '0;
            end
            if (i_cmd.wlink && idx_is_root) begin
                r_root_valid[r_idx[ldt_pkg::BYTE_W-1:0]] <= 1'b1;
            end
            if (i_cmd.wnew) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.hp        = r_hp;
    assign o_sts.full      = r_next_free >= ldt_pkg::t_count'(ldt_pkg::TABLE_DEPTH);
    assign o_sts.has_first = cur.has_first;
    assign o_sts.byte_eq   = cur.byte_val == r_b;
    assign o_sts.link_ok   = go_left ? cur.has_left : cur.has_right;
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_sts.init_busy = r_init_busy;

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_code       = ldt_pkg::OUT_CODE_W'(r_out_code);
    assign o_table_full = r_out_full;

endmodule

/* rtl/core/ldt_ctrl.sv */
// Controller: sequences decode, tree walk, table writes and result hand-off.
`timescale 1ns / 1ps

module ldt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ldt_pkg::t_dp_sts i_sts,
    output ldt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EV_ROOT,
        S_EV_WALK,
        S_WLINK_ROOT,
        S_WLINK_CHILD,
        S_WNEW,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_sts.init_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    ldt_pkg::OP_CLEAR: begin
                        o_cmd.clear   = 1'b1;
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = ldt_pkg::RES_ZERO;
                        n_state       = S_EMIT;
                    end
                    ldt_pkg::OP_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.set_res = 1'b1;
                            o_cmd.res     = ldt_pkg::RES_FULL;
                            n_state       = S_EMIT;
                        end else begin
                            n_state = S_WNEW;
                        end
                    end
                    ldt_pkg::OP_LOOKUP: begin
                        if (!i_sts.hp) begin
                            o_cmd.set_res = 1'b1;
                            o_cmd.res     = ldt_pkg::RES_BYTE;
                            n_state       = S_EMIT;
                        end else begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_EV_ROOT;
                        end
                    end
                    default: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = ldt_pkg::RES_ZERO;
                        n_state       = S_EMIT;
                    end
                endcase
            end
            S_EV_ROOT: begin
                o_cmd.link = ldt_pkg::LINK_FIRST;
                if (i_sts.has_first) begin
                    o_cmd.follow = 1'b1;
                    o_cmd.rd     = 1'b1;
                    n_state      = S_EV_WALK;
                end else if (i_sts.full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ldt_pkg::RES_FULL;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_WLINK_ROOT;
                end
            end
            S_EV_WALK: begin
                o_cmd.link = ldt_pkg::LINK_CHILD;
                if (i_sts.byte_eq) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ldt_pkg::RES_HIT;
                    n_state       = S_EMIT;
                end else if (i_sts.link_ok) begin
                    o_cmd.follow = 1'b1;
                    o_cmd.rd     = 1'b1;
                end else if (i_sts.full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ldt_pkg::RES_FULL;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_WLINK_CHILD;
                end
            end
            S_WLINK_ROOT: begin
                o_cmd.link  = ldt_pkg::LINK_FIRST;
                o_cmd.wlink = 1'b1;
                n_state     = S_WNEW;
            end
            S_WLINK_CHILD: begin
                o_cmd.link  = ldt_pkg::LINK_CHILD;
                o_cmd.wlink = 1'b1;
                n_state     = S_WNEW;
            end
            S_WNEW: begin
                o_cmd.wnew    = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ldt_pkg::RES_NEW;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.init_busy;

endmodule

/* rtl/core/lzw_dictionary_tree_lookup.sv */
// Top level of the LZW dictionary tree lookup block.
// Holds a 4096-entry LZW code table in one single-port-write, registered-read memory.
// After reset a clearing pass writes every entry once, during which the input is not
// ready. One transaction is worked on at a time. Clear, unused operations, empty-prefix
// lookups and refused appends go from decode straight to the output register; a
// successful append first writes its new entry. A lookup with a prefix decodes and
// reads its root, then visits child-tree nodes (one memory read each), and when a new
// entry is linked in writes the link and then the new entry. The hand-off waits while
// the output register still holds an untaken result. The input is ready again once the
// result is loaded into the output register, which holds it until taken.
// Clear takes effect at once: root entries carry valid bits, and entries above them
// keep their contents until written again.
`timescale 1ns / 1ps

module lzw_dictionary_tree_lookup (
    input logic  i_clk,
    input logic  i_rst_n,
    ldt_in_if.sink    i_in,
    ldt_out_if.source o_out
);

    ldt_pkg::t_dp_cmd cmd;
    ldt_pkg::t_dp_sts sts;
    logic             in_ready;

    ldt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ldt_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_operation      (i_in.operation),
        .i_prefix_present (i_in.prefix_present),
        .i_prefix_code    (i_in.prefix_code),
        .i_next_byte      (i_in.next_byte),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_found          (o_out.found),
        .o_code           (o_out.code),
        .o_table_full     (o_out.table_full)
    );

    assign i_in.ready = in_ready;

endmodule

/* rtl/core/ldt_checker.sv */
// Port-level checker for the LZW dictionary tree lookup block, with its bind.
`timescale 1ns / 1ps

module ldt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [11:0] i_code,
    input logic        i_table_full
);

    // One transaction in flight: no acceptance in the cycle after one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while a transaction is in flight");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_table_full) |-> (!i_found && i_code == 12'd0))
        else $error("refused insert reported with found or nonzero code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_found) && $stable(i_code) && $stable(i_table_full)))
        else $error("stalled result changed");

endmodule

bind lzw_dictionary_tree_lookup ldt_checker u_ldt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.found),
    .i_code       (o_out.code),
    .i_table_full (o_out.table_full)
);
